// ===== rtl/prq_pkg.sv =====
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and constants for the priority ready-queue scheduler: event
// codes, sequencer states and the request/status records of the queue table.
// ----------------------------------------------------------------------------
package prq_pkg;

   localparam int MODE_W  = 3;
   localparam int PRIO_W  = 5;
   localparam int TID_W   = 3;
   localparam int RTHR_W  = 3;
   localparam int RVAL_W  = 5;

   // widest slot and level index over the supported parameter range
   localparam int SLOT_IDX_MAX_W  = 6;
   localparam int LEVEL_IDX_MAX_W = 6;

   localparam logic [RVAL_W-1:0] RVAL_NO_SLOT = '1;  // -1
   localparam logic [RVAL_W-1:0] RVAL_ZERO    = '0;

   typedef enum logic [MODE_W-1:0] {
      MODE_CREATE = 3'd0,
      MODE_EXIT   = 3'd1,
      MODE_YIELD  = 3'd2,
      MODE_SLEEP  = 3'd3,
      MODE_WAKE   = 3'd4,
      MODE_GETID  = 3'd5,
      MODE_CHPRIO = 3'd6,
      MODE_SERR   = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_APPLY,
      ST_PUSH_A,
      ST_PUSH_B,
      ST_DISPATCH
   } seq_state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_POP,
      OP_PUSH,
      OP_CLEAR,
      OP_ALLOC,
      OP_SETLVL
   } tbl_code_type;

   typedef struct packed {
      tbl_code_type                code;
      logic [SLOT_IDX_MAX_W-1:0]   slot;
      logic [LEVEL_IDX_MAX_W-1:0]  level;
   } tbl_op_type;

   typedef struct packed {
      logic                        free_found;
      logic [SLOT_IDX_MAX_W-1:0]   free_slot;
      logic                        disp_found;
      logic [SLOT_IDX_MAX_W-1:0]   disp_slot;
      logic [LEVEL_IDX_MAX_W-1:0]  slot_level;
   } tbl_status_type;

endpackage

// ===== rtl/prq_req_if.sv =====
// ----------------------------------------------------------------------------
// prq_req_if
// Event channel: valid/ready handshake with the kernel event payload.
// ----------------------------------------------------------------------------
interface prq_req_if import prq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic signed [PRIO_W-1:0] priority_req;
   logic [TID_W-1:0]         thread_id;

   modport source (output valid, output mode, output priority_req, output thread_id,
                   input ready);
   modport sink   (input valid, input mode, input priority_req, input thread_id,
                   output ready);
endinterface

// ===== rtl/prq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// prq_rsp_if
// Result channel: valid/ready handshake with the dispatch result payload.
// ----------------------------------------------------------------------------
interface prq_rsp_if import prq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [RTHR_W-1:0]        running_thread;
   logic signed [RVAL_W-1:0] return_value;
   logic                     return_valid;
   logic                     halted;

   modport source (output valid, output running_thread, output return_value,
                   output return_valid, output halted, input ready);
   modport sink   (input valid, input running_thread, input return_value,
                   input return_valid, input halted, output ready);
endinterface

// ===== rtl/priority_ready_queue_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_core
// Hardware thread scheduler with fixed-priority FIFO ready queues.
//
// req_if carries one kernel event (mode, priority_req, thread_id) from the
// running thread; rsp_if returns one result per event: the dispatched slot,
// the return value and its valid flag, and the sticky halted flag.
// Between an event's transfer on req_if and rsp_if.valid, the queue table
// performs one edit per cycle (pop caller, apply event, push caller, push
// target) and then the dispatch encoders are sampled.
// One event is in flight at a time; req_if.ready stays low while an event
// is being worked and while its result waits, so a stalled receiver holds
// the result registers steady and blocks new events.
// Reset (synchronous) empties every queue, frees every slot, clears the
// halt flag and leaves no thread running; the first event should be create.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler_core import prq_pkg::*; #(
   parameter int THREADS = 8,
   parameter int LEVELS  = 16
) (
   input  logic      clock,
   input  logic      reset,
   prq_req_if.sink   req_if,
   prq_rsp_if.source rsp_if
);
   tbl_op_type     tbl_op;
   tbl_status_type tbl_status;

   prq_table #(
      .THREADS (THREADS),
      .LEVELS  (LEVELS)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .op     (tbl_op),
      .status (tbl_status)
   );

   prq_seq #(
      .THREADS (THREADS),
      .LEVELS  (LEVELS)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .status (tbl_status),
      .op     (tbl_op)
   );

endmodule

// ===== rtl/prq_table.sv =====
// ----------------------------------------------------------------------------
// prq_table
// Thread slot table and per-level FIFO ready queues. Applies one queue edit
// (pop head, push tail, clear, allocate, set level) per cycle and reports the
// first free slot and the head of the highest-priority non-empty level.
// ----------------------------------------------------------------------------
module prq_table import prq_pkg::*; #(
   parameter int THREADS = 8,
   parameter int LEVELS  = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  tbl_op_type     op,
   output tbl_status_type status
);
   localparam int IW = $clog2(THREADS);
   localparam int LW = $clog2(LEVELS);

   logic [THREADS-1:0] used_ff, used_in;
   logic [THREADS-1:0] ready_ff, ready_in;
   logic [THREADS-1:0] link_vld_ff, link_vld_in;
   logic [LEVELS-1:0]  nonempty_ff, nonempty_in;
   logic [LW-1:0]      level_ff [THREADS];
   logic [LW-1:0]      level_in [THREADS];
   logic [IW-1:0]      link_ff  [THREADS];
   logic [IW-1:0]      link_in  [THREADS];
   logic [IW-1:0]      head_ff  [LEVELS];
   logic [IW-1:0]      head_in  [LEVELS];
   logic [IW-1:0]      tail_ff  [LEVELS];
   logic [IW-1:0]      tail_in  [LEVELS];
   logic [IW-1:0]      last_slot_ff, last_slot_in;

   logic [IW-1:0] s;
   logic [LW-1:0] lv_s;
   logic [LW-1:0] lv_new;

   assign s            = IW'(op.slot);
   assign lv_s         = level_ff[s];
   assign lv_new       = LW'(op.level);
   assign last_slot_in = s;

   always_comb begin
      used_in     = used_ff;
      ready_in    = ready_ff;
      link_vld_in = link_vld_ff;
      nonempty_in = nonempty_ff;
      level_in    = level_ff;
      link_in     = link_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      unique case (op.code)
         OP_NONE: ;
         OP_POP: begin
            // the slot popped is always the head of its level
            if (ready_ff[s]) begin
               head_in[lv_s]     = link_ff[s];
               nonempty_in[lv_s] = link_vld_ff[s];
               ready_in[s]       = 1'b0;
               link_vld_in[s]    = 1'b0;
            end
         end
         OP_PUSH: begin
            if (used_ff[s] && !ready_ff[s]) begin
               link_vld_in[s] = 1'b0;
               if (nonempty_ff[lv_s]) begin
                  link_in[tail_ff[lv_s]]     = s;
                  link_vld_in[tail_ff[lv_s]] = 1'b1;
               end else begin
                  head_in[lv_s]     = s;
                  nonempty_in[lv_s] = 1'b1;
               end
               tail_in[lv_s] = s;
               ready_in[s]   = 1'b1;
            end
         end
         OP_CLEAR: begin
            used_in[s]     = 1'b0;
            ready_in[s]    = 1'b0;
            link_vld_in[s] = 1'b0;
            level_in[s]    = '0;
         end
         OP_ALLOC: begin
            used_in[s]     = 1'b1;
            ready_in[s]    = 1'b0;
            link_vld_in[s] = 1'b0;
            level_in[s]    = lv_new;
         end
         OP_SETLVL: begin
            level_in[s] = lv_new;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         ready_ff    <= '0;
         link_vld_ff <= '0;
         nonempty_ff <= '0;
      end else begin
         used_ff     <= used_in;
         ready_ff    <= ready_in;
         link_vld_ff <= link_vld_in;
         nonempty_ff <= nonempty_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff     <= level_in;
      link_ff      <= link_in;
      head_ff      <= head_in;
      tail_ff      <= tail_in;
      last_slot_ff <= last_slot_in;
   end

   // priority encoders: lowest free slot, lowest non-empty level
   // slot_level is the level of the slot addressed in the previous cycle
   always_comb begin
      status            = '0;
      status.slot_level = LEVEL_IDX_MAX_W'(level_ff[last_slot_ff]);
      for (int i = THREADS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            status.free_found = 1'b1;
            status.free_slot  = SLOT_IDX_MAX_W'(i);
         end
      end
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (nonempty_ff[l]) begin
            status.disp_found = 1'b1;
            status.disp_slot  = SLOT_IDX_MAX_W'(head_ff[l]);
         end
      end
   end

   a_ready_used: assert property (@(posedge clock) disable iff (reset)
      (ready_ff & ~used_ff) == '0)
      else $error("ready slot not in use");

   a_head_ready: assert property (@(posedge clock) disable iff (reset)
      status.disp_found |-> ready_ff[IW'(status.disp_slot)])
      else $error("queue head not marked ready");

   a_pop_head: assert property (@(posedge clock) disable iff (reset)
      (op.code == OP_POP) |-> (ready_ff[s] && nonempty_ff[lv_s] && head_ff[lv_s] == s))
      else $error("pop of a slot that is not a queue head");

endmodule

// ===== rtl/prq_seq.sv =====
// ----------------------------------------------------------------------------
// prq_seq
// Event sequencer: takes one event, drives the queue table through pop,
// apply, two pushes and dispatch, then holds the result for transfer.
// ----------------------------------------------------------------------------
module prq_seq import prq_pkg::*; #(
   parameter int THREADS = 8,
   parameter int LEVELS  = 16
) (
   input  logic           clock,
   input  logic           reset,
   prq_req_if.sink        req_if,
   prq_rsp_if.source      rsp_if,
   input  tbl_status_type status,
   output tbl_op_type     op
);
   localparam int IW = $clog2(THREADS);
   localparam int LW = $clog2(LEVELS);

   seq_state_type state_ff, state_in;

   mode_type          mode_ff, mode_in;
   logic [PRIO_W-1:0] pr_ff, pr_in;
   logic [TID_W-1:0]  tid_ff, tid_in;
   logic              halt_ff, halt_in;
   logic              run_valid_ff, run_valid_in;
   logic [IW-1:0]     cur_ff, cur_in;
   logic [RVAL_W-1:0] rv_ff, rv_in;
   logic              ret_vld_ff, ret_vld_in;
   logic              push_a_ff, push_a_in;
   logic              push_b_ff, push_b_in;
   logic [IW-1:0]     b_slot_ff, b_slot_in;

   logic              out_vld_ff, out_vld_in;
   logic [RTHR_W-1:0] out_thread_ff, out_thread_in;
   logic [RVAL_W-1:0] out_rv_ff, out_rv_in;
   logic              out_rvld_ff, out_rvld_in;
   logic              out_halt_ff, out_halt_in;

   logic          req_fire;
   logic          active;
   logic [LW-1:0] sat_lvl;

   assign req_if.ready = (state_ff == ST_IDLE) && !out_vld_ff;
   assign req_fire     = req_if.valid && req_if.ready;
   assign active       = !halt_ff;

   assign rsp_if.valid          = out_vld_ff;
   assign rsp_if.running_thread = out_thread_ff;
   assign rsp_if.return_value   = out_rv_ff;
   assign rsp_if.return_valid   = out_rvld_ff;
   assign rsp_if.halted         = out_halt_ff;

   // requested level clamped to the implemented range
   always_comb begin
      if (pr_ff[PRIO_W-1]) begin
         sat_lvl = '0;
      end else if (32'(pr_ff[PRIO_W-2:0]) > 32'(LEVELS - 1)) begin
         sat_lvl = LW'(LEVELS - 1);
      end else begin
         sat_lvl = LW'(pr_ff[PRIO_W-2:0]);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_fire) state_in = ST_POP;
         ST_POP:      state_in = ST_APPLY;
         ST_APPLY:    state_in = ST_PUSH_A;
         ST_PUSH_A:   state_in = ST_PUSH_B;
         ST_PUSH_B:   state_in = ST_DISPATCH;
         ST_DISPATCH: state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      op            = '0;
      op.code       = OP_NONE;
      mode_in       = mode_ff;
      pr_in         = pr_ff;
      tid_in        = tid_ff;
      halt_in       = halt_ff;
      run_valid_in  = run_valid_ff;
      cur_in        = cur_ff;
      rv_in         = rv_ff;
      ret_vld_in    = ret_vld_ff;
      push_a_in     = push_a_ff;
      push_b_in     = push_b_ff;
      b_slot_in     = b_slot_ff;
      out_vld_in    = out_vld_ff;
      out_thread_in = out_thread_ff;
      out_rv_in     = out_rv_ff;
      out_rvld_in   = out_rvld_ff;
      out_halt_in   = out_halt_ff;

      if (out_vld_ff && rsp_if.ready) out_vld_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mode_in = mode_type'(req_if.mode);
               pr_in   = req_if.priority_req;
               tid_in  = req_if.thread_id;
            end
         end
         ST_POP: begin
            if (active && run_valid_ff) begin
               op.code = OP_POP;
               op.slot = SLOT_IDX_MAX_W'(cur_ff);
            end
         end
         ST_APPLY: begin
            op.slot = SLOT_IDX_MAX_W'(cur_ff);
            if (active) begin
               rv_in      = RVAL_ZERO;
               ret_vld_in = !(mode_ff == MODE_EXIT || mode_ff == MODE_SERR);
               push_a_in  = 1'b0;
               push_b_in  = 1'b0;
               unique case (mode_ff)
                  MODE_CREATE: begin
                     if (status.free_found) begin
                        op.code   = OP_ALLOC;
                        op.slot   = status.free_slot;
                        op.level  = LEVEL_IDX_MAX_W'(sat_lvl);
                        push_a_in = run_valid_ff;
                        push_b_in = 1'b1;
                        b_slot_in = IW'(status.free_slot);
                        rv_in     = RVAL_W'(status.free_slot);
                     end else begin
                        // caller stays off the queues
                        rv_in = RVAL_NO_SLOT;
                     end
                  end
                  MODE_EXIT, MODE_SERR: begin
                     if (run_valid_ff) op.code = OP_CLEAR;
                  end
                  MODE_YIELD: push_a_in = run_valid_ff;
                  MODE_SLEEP: ;
                  MODE_WAKE: begin
                     push_a_in = run_valid_ff;
                     push_b_in = 32'(tid_ff) < 32'(THREADS);
                     b_slot_in = IW'(tid_ff);
                  end
                  MODE_GETID: begin
                     push_a_in = run_valid_ff;
                     if (run_valid_ff) rv_in = RVAL_W'(cur_ff);
                  end
                  MODE_CHPRIO: begin
                     if (run_valid_ff) begin
                        rv_in     = RVAL_W'(status.slot_level);
                        push_a_in = 1'b1;
                        if (!pr_ff[PRIO_W-1]) begin
                           op.code  = OP_SETLVL;
                           op.level = LEVEL_IDX_MAX_W'(sat_lvl);
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_PUSH_A: begin
            if (active && push_a_ff) begin
               op.code = OP_PUSH;
               op.slot = SLOT_IDX_MAX_W'(cur_ff);
            end
         end
         ST_PUSH_B: begin
            // an already-ready slot (including the caller) is left alone
            if (active && push_b_ff) begin
               op.code = OP_PUSH;
               op.slot = SLOT_IDX_MAX_W'(b_slot_ff);
            end
         end
         ST_DISPATCH: begin
            out_vld_in = 1'b1;
            if (!active) begin
               out_thread_in = '0;
               out_rv_in     = RVAL_ZERO;
               out_rvld_in   = 1'b0;
               out_halt_in   = 1'b1;
            end else if (status.disp_found) begin
               run_valid_in  = 1'b1;
               cur_in        = IW'(status.disp_slot);
               out_thread_in = RTHR_W'(status.disp_slot);
               out_rv_in     = rv_ff;
               out_rvld_in   = ret_vld_ff;
               out_halt_in   = 1'b0;
            end else begin
               halt_in       = 1'b1;
               run_valid_in  = 1'b0;
               out_thread_in = '0;
               out_rv_in     = rv_ff;
               out_rvld_in   = ret_vld_ff;
               out_halt_in   = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         halt_ff      <= 1'b0;
         run_valid_ff <= 1'b0;
         out_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         halt_ff      <= halt_in;
         run_valid_ff <= run_valid_in;
         out_vld_ff   <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      pr_ff         <= pr_in;
      tid_ff        <= tid_in;
      cur_ff        <= cur_in;
      rv_ff         <= rv_in;
      ret_vld_ff    <= ret_vld_in;
      push_a_ff     <= push_a_in;
      push_b_ff     <= push_b_in;
      b_slot_ff     <= b_slot_in;
      out_thread_ff <= out_thread_in;
      out_rv_ff     <= out_rv_in;
      out_rvld_ff   <= out_rvld_in;
      out_halt_ff   <= out_halt_in;
   end

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt flag dropped without reset");

   a_run_vs_halt: assert property (@(posedge clock) disable iff (reset)
      !(run_valid_ff && halt_ff))
      else $error("running thread held while halted");

   a_rsp_after_dispatch: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(state_ff == ST_DISPATCH))
      else $error("result raised outside dispatch");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the priority ready-queue scheduler. Kernel events
// are pushed through the request channel and every dispatch result is
// compared field by field with an in-bench model of the slot table and the
// per-level FIFO queues. A directed opening exercises create, saturation,
// wake corner cases and a full table. Random traffic is then steered away
// from an early halt, and the run ends by exiting threads into the sticky
// halt and sending a few events while halted. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
   import prq_pkg::*;

   localparam int NTHR = 8;
   localparam int NLVL = 16;
   localparam logic [3:0] SLOT_NIL = 4'd8;
   localparam int RANDOM_EVENTS = 500;

   typedef struct packed {
      mode_type                 mode;
      logic signed [PRIO_W-1:0] prio;
      logic [TID_W-1:0]         tid;
   } sched_event_type;

   typedef struct packed {
      logic [RTHR_W-1:0]        thread;
      logic signed [RVAL_W-1:0] retval;
      logic                     retvalid;
      logic                     halted;
   } dispatch_type;

   typedef struct packed {
      logic [NTHR-1:0]       used;
      logic [NTHR-1:0]       ready;
      logic [NTHR-1:0][3:0]  level;
      logic [NTHR-1:0][3:0]  link;
      logic [NLVL-1:0][3:0]  head;
      logic [NLVL-1:0][3:0]  tail;
      logic [3:0]            run;
      logic                  run_ok;
      logic                  halt;
   } sched_state_type;

   class dispatch_scoreboard;
      sched_state_type st;
      dispatch_type    pending_dispatch[$];
      int              failures;
      int              n_events;
      int              n_checked;
      int              n_refused;
      int              mode_seen[8];

      function new();
         int i;
         st = '0;
         for (i = 0; i < NTHR; i++) st.link[i] = SLOT_NIL;
         for (i = 0; i < NLVL; i++) begin
            st.head[i] = SLOT_NIL;
            st.tail[i] = SLOT_NIL;
         end
         failures  = 0;
         n_events  = 0;
         n_checked = 0;
         n_refused = 0;
         for (i = 0; i < 8; i++) mode_seen[i] = 0;
      endfunction

      function logic [3:0] clamp_level(int p);
         if (p < 0) return 4'd0;
         if (p > NLVL - 1) return 4'(NLVL - 1);
         return 4'(p);
      endfunction

      function void free_slot(int s);
         st.used[s]  = 1'b0;
         st.ready[s] = 1'b0;
         st.level[s] = 4'd0;
         st.link[s]  = SLOT_NIL;
      endfunction

      // append at the tail of the slot's level
      function void queue_slot(int s);
         int lv;
         if (s >= NTHR || st.ready[s]) return;
         lv = st.level[s];
         st.link[s] = SLOT_NIL;
         if (st.tail[lv] != SLOT_NIL) st.link[st.tail[lv]] = 4'(s);
         else st.head[lv] = 4'(s);
         st.tail[lv] = 4'(s);
         st.ready[s] = 1'b1;
      endfunction

      function void unqueue_slot(int s);
         int lv, prev, cur, n;
         if (s >= NTHR || !st.ready[s]) return;
         lv   = st.level[s];
         prev = SLOT_NIL;
         cur  = st.head[lv];
         for (n = 0; n < NTHR && cur != SLOT_NIL && cur != s; n++) begin
            prev = cur;
            cur  = st.link[cur];
         end
         if (cur == s) begin
            if (prev == SLOT_NIL) st.head[lv] = st.link[s];
            else st.link[prev] = st.link[s];
            if (st.tail[lv] == s) st.tail[lv] = 4'(prev);
         end
         st.ready[s] = 1'b0;
         st.link[s]  = SLOT_NIL;
      endfunction

      // apply one event to the table and return the dispatch it produces
      function dispatch_type schedule_event(sched_event_type ev);
         dispatch_type r;
         int           lreq, i, rv, cur;
         bit           have, rvalid;
         r = '0;
         if (st.halt) begin
            r.halted = 1'b1;
            return r;
         end
         lreq   = $signed(ev.prio);
         have   = st.run_ok && st.run < NTHR;
         cur    = st.run;
         rv     = 0;
         rvalid = 1'b1;
         if (have) unqueue_slot(cur);
         case (ev.mode)
            MODE_CREATE: begin
               for (i = 0; i < NTHR && st.used[i]; i++) begin
               end
               if (i == NTHR) begin
                  rv = -1;   // table full: caller left asleep
               end else begin
                  if (have) queue_slot(cur);
                  free_slot(i);
                  st.used[i]  = 1'b1;
                  st.level[i] = clamp_level(lreq);
                  queue_slot(i);
                  rv = i;
               end
            end
            MODE_EXIT, MODE_SERR: begin
               if (have) free_slot(cur);
               rvalid = 1'b0;
            end
            MODE_YIELD: if (have) queue_slot(cur);
            MODE_SLEEP: ;
            MODE_WAKE: begin
               if (have) queue_slot(cur);
               if (ev.tid < NTHR && st.used[ev.tid]) queue_slot(ev.tid);
            end
            MODE_GETID: begin
               if (have) begin
                  queue_slot(cur);
                  rv = cur;
               end
            end
            default: begin
               if (have) begin
                  rv = st.level[cur];
                  if (lreq >= 0) st.level[cur] = clamp_level(lreq);
                  queue_slot(cur);
               end
            end
         endcase
         for (i = 0; i < NLVL && st.head[i] == SLOT_NIL; i++) begin
         end
         if (i == NLVL) begin
            st.halt   = 1'b1;
            st.run_ok = 1'b0;
            st.run    = 4'd0;
         end else begin
            st.run    = st.head[i];
            st.run_ok = 1'b1;
         end
         r.thread   = st.run_ok ? st.run[2:0] : 3'd0;
         r.retval   = rv[RVAL_W-1:0];
         r.retvalid = rvalid;
         r.halted   = st.halt;
         return r;
      endfunction

      function bit would_halt(sched_event_type ev);
         sched_state_type keep;
         dispatch_type    r;
         keep = st;
         r    = schedule_event(ev);
         st   = keep;
         return r.halted;
      endfunction

      function void note_event(sched_event_type ev);
         dispatch_type r;
         r = schedule_event(ev);
         pending_dispatch.push_back(r);
         n_events++;
         mode_seen[ev.mode]++;
         if (ev.mode == MODE_CREATE && r.retvalid && r.retval == -1) n_refused++;
      endfunction

      function void check_result(dispatch_type got);
         dispatch_type exp;
         if (pending_dispatch.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: thread %0d rv %0d valid %0d halted %0d",
                        got.thread, got.retval, got.retvalid, got.halted);
            return;
         end
         exp = pending_dispatch.pop_front();
         n_checked++;
         if (got.thread !== exp.thread || got.retval !== exp.retval ||
             got.retvalid !== exp.retvalid || got.halted !== exp.halted) begin
            failures++;
            if (failures <= 10) begin
               $display("mismatch on result %0d: exp thread %0d rv %0d valid %0d halted %0d,",
                        n_checked, exp.thread, exp.retval, exp.retvalid, exp.halted);
               $display("   got thread %0d rv %0d valid %0d halted %0d",
                        got.thread, got.retval, got.retvalid, got.halted);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   prq_req_if req_bus ();
   prq_rsp_if rsp_bus ();

   priority_ready_queue_scheduler_core #(
      .THREADS (NTHR),
      .LEVELS  (NLVL)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   dispatch_scoreboard sb = new();
   int sent = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic sched_event_type make_event(mode_type m, int p, int t);
      sched_event_type ev;
      ev.mode = m;
      ev.prio = p[PRIO_W-1:0];
      ev.tid  = t[TID_W-1:0];
      return ev;
   endfunction

   function automatic sched_event_type pick_event();
      sched_event_type ev;
      int              nused, cw, m, k;
      logic [NTHR-1:0] asleep;
      nused   = $countones(sb.st.used);
      asleep  = sb.st.used & ~sb.st.ready;
      ev.prio = PRIO_W'($urandom);
      ev.tid  = TID_W'($urandom);
      cw = (nused < 3) ? 40 : (nused < 7) ? 20 : 10;
      if ($urandom_range(0, 99) < cw) begin
         ev.mode = MODE_CREATE;
      end else begin
         m = $urandom_range(0, 19);
         if (m < 2)       ev.mode = MODE_EXIT;
         else if (m < 3)  ev.mode = MODE_SERR;
         else if (m < 6)  ev.mode = MODE_YIELD;
         else if (m < 9)  ev.mode = MODE_SLEEP;
         else if (m < 14) ev.mode = MODE_WAKE;
         else if (m < 16) ev.mode = MODE_GETID;
         else             ev.mode = MODE_CHPRIO;
      end
      // mostly a few busy levels so FIFO order within a level gets exercised
      if ((ev.mode == MODE_CREATE || ev.mode == MODE_CHPRIO) && $urandom_range(0, 9) < 7)
         ev.prio = PRIO_W'($urandom_range(0, 3));
      if (ev.mode == MODE_WAKE && asleep != '0 && $urandom_range(0, 3) != 0) begin
         k = $urandom_range(0, NTHR - 1);
         while (!asleep[k]) k = (k + 1) % NTHR;
         ev.tid = TID_W'(k);
      end
      return ev;
   endfunction

   task automatic send_event(input sched_event_type ev);
      int gap;
      gap = ((sent / 60) % 4 == 3) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.mode         <= ev.mode;
      req_bus.priority_req <= ev.prio;
      req_bus.thread_id    <= ev.tid;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      sb.note_event(ev);
      sent++;
   endtask

   initial begin : result_sink
      int           hold;
      dispatch_type got;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         hold = ((sb.n_checked / 50) % 4 == 1) ? 0 : $urandom_range(0, 8);
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            // stall either from the result's arrival or from the last transfer
            if ($urandom_range(0, 1)) begin
               do @(posedge clock); while (!rsp_bus.valid);
               hold--;
            end
            repeat (hold) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         got.thread   = rsp_bus.running_thread;
         got.retval   = rsp_bus.return_value;
         got.retvalid = rsp_bus.return_valid;
         got.halted   = rsp_bus.halted;
         sb.check_result(got);
      end
   end

   initial begin : stimulus
      sched_event_type opening[$];
      sched_event_type ev;
      int              k, tries;
      req_bus.valid        <= 1'b0;
      req_bus.mode         <= MODE_CREATE;
      req_bus.priority_req <= '0;
      req_bus.thread_id    <= '0;
      reset                <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // create with nothing running, level clamping, FIFO order, wake corners,
      // a full table and a refused create, then exit and soft error
      opening = '{make_event(MODE_CREATE, 3, 0),   make_event(MODE_GETID, 0, 7),
                  make_event(MODE_CREATE, 0, 0),   make_event(MODE_CREATE, -16, 5),
                  make_event(MODE_CREATE, 15, 0),  make_event(MODE_YIELD, 15, 7),
                  make_event(MODE_CHPRIO, -1, 0),  make_event(MODE_CHPRIO, 15, 0),
                  make_event(MODE_SLEEP, -16, 7),  make_event(MODE_WAKE, 0, 1),
                  make_event(MODE_WAKE, 0, 1),     make_event(MODE_WAKE, 0, 3),
                  make_event(MODE_WAKE, 0, 7),     make_event(MODE_CREATE, 5, 0),
                  make_event(MODE_CREATE, 5, 0),   make_event(MODE_CREATE, 5, 0),
                  make_event(MODE_CREATE, 5, 0),   make_event(MODE_CREATE, 1, 0),
                  make_event(MODE_EXIT, -1, 7),    make_event(MODE_SERR, 15, 0),
                  make_event(MODE_CHPRIO, 2, 0),   make_event(MODE_WAKE, 0, 1),
                  make_event(MODE_GETID, 0, 0)};
      foreach (opening[i])
         if (!sb.would_halt(opening[i])) send_event(opening[i]);

      for (k = 0; k < RANDOM_EVENTS; k++) begin
         tries = 0;
         do begin
            ev = pick_event();
            tries++;
         end while (sb.would_halt(ev) && tries < 50);
         if (sb.would_halt(ev)) ev = make_event(MODE_YIELD, 0, 0);
         send_event(ev);
      end

      // run the table dry into the sticky halt, then a few ignored events
      while (!sb.st.halt) send_event(make_event(MODE_EXIT, $urandom, $urandom));
      send_event(make_event(MODE_CREATE, 2, 0));
      send_event(make_event(MODE_GETID, 0, 0));
      send_event(make_event(MODE_WAKE, 0, 3));
      send_event(make_event(MODE_SERR, 0, 0));
      req_bus.valid <= 1'b0;

      while (sb.pending_dispatch.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);

      $display("%0d events sent (%0d create, %0d refused, %0d wake, %0d priority change)",
               sb.n_events, sb.mode_seen[MODE_CREATE], sb.n_refused,
               sb.mode_seen[MODE_WAKE], sb.mode_seen[MODE_CHPRIO]);
      $display("%0d dispatch results checked, %0d failures, halted at end: %0d",
               sb.n_checked, sb.failures, sb.st.halt);
      if (sb.failures == 0 && sb.pending_dispatch.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/prq_pkg.sv
rtl/prq_req_if.sv
rtl/prq_rsp_if.sv
rtl/prq_table.sv
rtl/prq_seq.sv
rtl/priority_ready_queue_scheduler_core.sv
bench/tb.sv
